>>> design/grdc_pkg.sv
// ----------------------------------------------------------------------------
// grdc_pkg
// Shared types and constants for the grid ray DDA caster.
// ----------------------------------------------------------------------------
package grdc_pkg;

    localparam int DEF_SCREEN_COLUMNS = 1024;
    localparam int DEF_MAP_SIDE       = 64;
    localparam int DEF_FRAC_BITS      = 16;

    localparam int POS_W    = 22;
    localparam int VEC_W    = 18;
    localparam int COL_W    = 10;
    localparam int CELL_W   = 6;
    localparam int DIST_W   = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [POS_W-1:0] RST_POS_X  = '0;
    localparam logic [POS_W-1:0] RST_POS_Y  = '0;
    localparam logic signed [VEC_W-1:0] RST_DIR_X   = 18'sd65536;
    localparam logic signed [VEC_W-1:0] RST_DIR_Y   = 18'sd0;
    localparam logic signed [VEC_W-1:0] RST_PLANE_X = 18'sd0;
    localparam logic signed [VEC_W-1:0] RST_PLANE_Y = 18'sd43254;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X   = 3'd0,
        CFG_POS_Y   = 3'd1,
        CFG_DIR_X   = 3'd2,
        CFG_DIR_Y   = 3'd3,
        CFG_PLANE_X = 3'd4,
        CFG_PLANE_Y = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FACE_POS_X = 2'd0,
        FACE_NEG_X = 2'd1,
        FACE_POS_Y = 2'd2,
        FACE_NEG_Y = 2'd3
    } t_face;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_CAST  = 1'b1
    } t_mode;

    typedef enum logic {
        ST_HIT = 1'b0,
        ST_OUT = 1'b1
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAM_GO,
        S_CAM_WAIT,
        S_RAY,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_FIRST,
        S_STEP,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

>>> design/grdc_div.sv
// ----------------------------------------------------------------------------
// grdc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grdc_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;

    always_comb begin
        rem_sh = {r_rem, r_q[NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (diff[DEN_W+1]) begin
                n_rem = rem_sh[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end else begin
                n_rem = diff[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> design/grdc_map.sv
// ----------------------------------------------------------------------------
// grdc_map
// One-bit wall map memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module grdc_map #(
    parameter int MAP_SIDE = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_we,
    input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]    i_waddr,
    input  logic                                    i_wdata,
    input  logic                                    i_re,
    input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]    i_raddr,
    output logic                                    o_rdata,
    output logic                                    o_ready
);
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);

    logic          r_mem [DEPTH];
    logic          r_rdata;
    logic          r_clr, n_clr;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    always_comb begin
        n_clr      = r_clr;
        n_clr_addr = r_clr_addr;
        if (r_clr) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                n_clr = 1'b0;
            end
        end
        wr_en   = r_clr | i_we;
        wr_addr = r_clr ? r_clr_addr : i_waddr;
        wr_data = r_clr ? 1'b0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr      <= n_clr;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clr;
endmodule

>>> design/grdc_ctrl.sv
// ----------------------------------------------------------------------------
// grdc_ctrl
// Cast sequencer: camera setup (shift or division) and delta setup on the
// shared divider, DDA walk with one map read per cell, result register.
// ----------------------------------------------------------------------------
module grdc_ctrl #(
    parameter int SCREEN_COLUMNS = 1024,
    parameter int MAP_SIDE       = 64,
    parameter int FRAC_BITS      = 16,
    parameter int DIV_NW         = 33,
    parameter int DIV_DW         = 31
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic [grdc_pkg::COL_W-1:0]            i_column,
    input  logic [grdc_pkg::CELL_W-1:0]           i_cell_x,
    input  logic [grdc_pkg::CELL_W-1:0]           i_cell_y,
    input  logic                                  i_cell_wall,
    input  logic [grdc_pkg::POS_W-1:0]            i_pos_x,
    input  logic [grdc_pkg::POS_W-1:0]            i_pos_y,
    input  logic signed [grdc_pkg::VEC_W-1:0]     i_dir_x,
    input  logic signed [grdc_pkg::VEC_W-1:0]     i_dir_y,
    input  logic signed [grdc_pkg::VEC_W-1:0]     i_plane_x,
    input  logic signed [grdc_pkg::VEC_W-1:0]     i_plane_y,
    output logic                                  o_div_start,
    output logic [DIV_NW-1:0]                     o_div_num,
    output logic [DIV_DW-1:0]                     o_div_den,
    input  logic                                  i_div_done,
    input  logic [DIV_NW-1:0]                     i_div_quot,
    input  logic                                  i_map_ready,
    output logic                                  o_map_we,
    output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]  o_map_waddr,
    output logic                                  o_map_wdata,
    output logic                                  o_map_re,
    output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]  o_map_raddr,
    input  logic                                  i_map_rdata,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [grdc_pkg::COL_W-1:0]            o_ray_column,
    output logic [grdc_pkg::CELL_W-1:0]           o_hit_x,
    output logic [grdc_pkg::CELL_W-1:0]           o_hit_y,
    output logic [1:0]                            o_face,
    output logic [grdc_pkg::DIST_W-1:0]           o_side_distance,
    output logic                                  o_status
);
    import grdc_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int CAM_W  = F + COL_W + 2;
    localparam int PW     = VEC_W + CAM_W;
    localparam int RAY_W  = PW - F + 1;
    localparam int PEXT_W = (F + 1 > POS_W + 1) ? F + 1 : POS_W + 1;
    localparam int MAP_W  = $clog2(MAP_SIDE);
    localparam int AW     = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int FD_W   = F + 1 + DIST_W;
    localparam bit COLS_POW2 = ((SCREEN_COLUMNS & (SCREEN_COLUMNS - 1)) == 0);
    localparam int COLS_LOG  = $clog2(SCREEN_COLUMNS);

    t_state                    r_state, n_state;
    logic [COL_W-1:0]          r_column, n_column;
    logic signed [CAM_W-1:0]   r_cam, n_cam;
    logic signed [RAY_W-1:0]   r_rx, n_rx, r_ry, n_ry;
    logic [DIST_W-1:0]         r_ddx, n_ddx, r_ddy, n_ddy;
    logic [DIST_W-1:0]         r_distx, n_distx, r_disty, n_disty;
    logic [MAP_W-1:0]          r_mx, n_mx, r_my, n_my;
    logic [CELL_W-1:0]         r_hx, n_hx, r_hy, n_hy;
    t_face                     r_face, n_face;
    logic [DIST_W-1:0]         r_side, n_side;
    t_status                   r_status, n_status;
    logic                      r_ovalid, n_ovalid;
    logic [COL_W-1:0]          r_o_col, n_o_col;
    logic [CELL_W-1:0]         r_o_hx, n_o_hx, r_o_hy, n_o_hy;
    t_face                     r_o_face, n_o_face;
    logic [DIST_W-1:0]         r_o_side, n_o_side;
    t_status                   r_o_status, n_o_status;

    logic                      in_acc;
    logic                      out_free;
    logic [CAM_W-1:0]          cam_q;
    logic signed [PW-1:0]      prod_x, prod_y;
    logic signed [PW-1:0]      shx, shy;
    logic [RAY_W-1:0]          abs_x, abs_y;
    logic                      rx_pos, ry_pos;
    logic [DIST_W-1:0]         quot_sat;
    logic [PEXT_W-1:0]         pex, pey, int_x, int_y;
    logic [F:0]                part_x, part_y;
    logic [FD_W-1:0]           fprod_x, fprod_y;
    logic [FD_W-F-1:0]         fsh_x, fsh_y;
    logic                      start_in;
    logic                      go_x;
    logic                      step_out;
    logic [MAP_W-1:0]          nx, ny;
    logic [DIST_W:0]           sum_x, sum_y;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        cam_q  = (CAM_W'(r_column) << (F + 1)) >> COLS_LOG;
        prod_x = i_plane_x * r_cam;
        prod_y = i_plane_y * r_cam;
        shx    = prod_x >>> F;
        shy    = prod_y >>> F;
        abs_x  = r_rx[RAY_W-1] ? RAY_W'(-r_rx) : RAY_W'(r_rx);
        abs_y  = r_ry[RAY_W-1] ? RAY_W'(-r_ry) : RAY_W'(r_ry);
        rx_pos = !r_rx[RAY_W-1] && (r_rx != '0);
        ry_pos = !r_ry[RAY_W-1] && (r_ry != '0);
        quot_sat = (i_div_quot > DIV_NW'(DIST_MAX)) ? DIST_MAX : DIST_W'(i_div_quot);
        pex    = PEXT_W'(i_pos_x);
        pey    = PEXT_W'(i_pos_y);
        int_x  = pex >> F;
        int_y  = pey >> F;
        part_x = rx_pos ? (F+1)'((F+1)'(1) << F) - (F+1)'(pex[F-1:0])
                        : (F+1)'(pex[F-1:0]);
        part_y = ry_pos ? (F+1)'((F+1)'(1) << F) - (F+1)'(pey[F-1:0])
                        : (F+1)'(pey[F-1:0]);
        fprod_x = FD_W'(part_x) * FD_W'(r_ddx);
        fprod_y = FD_W'(part_y) * FD_W'(r_ddy);
        fsh_x  = fprod_x[FD_W-1:F];
        fsh_y  = fprod_y[FD_W-1:F];
        start_in = (int_x < PEXT_W'(MAP_SIDE)) && (int_y < PEXT_W'(MAP_SIDE));
        go_x   = r_distx < r_disty;
        sum_x  = {1'b0, r_distx} + {1'b0, r_ddx};
        sum_y  = {1'b0, r_disty} + {1'b0, r_ddy};
        nx     = r_mx;
        ny     = r_my;
        if (go_x) begin
            step_out = rx_pos ? (r_mx == MAP_W'(MAP_SIDE - 1)) : (r_mx == '0);
            nx       = rx_pos ? r_mx + 1'b1 : r_mx - 1'b1;
        end else begin
            step_out = ry_pos ? (r_my == MAP_W'(MAP_SIDE - 1)) : (r_my == '0);
            ny       = ry_pos ? r_my + 1'b1 : r_my - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (t_mode'(i_mode) == MODE_CAST)) begin
                    n_state = S_CAM_GO;
                end
            end
            S_CAM_GO:   n_state = COLS_POW2 ? S_RAY : S_CAM_WAIT;
            S_CAM_WAIT: if (i_div_done) n_state = S_RAY;
            S_RAY:      n_state = S_DX_GO;
            S_DX_GO:    n_state = (r_rx == '0) ? S_DY_GO : S_DX_WAIT;
            S_DX_WAIT:  if (i_div_done) n_state = S_DY_GO;
            S_DY_GO:    n_state = (r_ry == '0) ? S_FIRST : S_DY_WAIT;
            S_DY_WAIT:  if (i_div_done) n_state = S_FIRST;
            S_FIRST:    n_state = start_in ? S_STEP : S_DONE;
            S_STEP:     n_state = step_out ? S_DONE : S_CHECK;
            S_CHECK:    n_state = i_map_rdata ? S_DONE : S_STEP;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_column   = r_column;
        n_cam      = r_cam;
        n_rx       = r_rx;
        n_ry       = r_ry;
        n_ddx      = r_ddx;
        n_ddy      = r_ddy;
        n_distx    = r_distx;
        n_disty    = r_disty;
        n_mx       = r_mx;
        n_my       = r_my;
        n_hx       = r_hx;
        n_hy       = r_hy;
        n_face     = r_face;
        n_side     = r_side;
        n_status   = r_status;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_o_col    = r_o_col;
        n_o_hx     = r_o_hx;
        n_o_hy     = r_o_hy;
        n_o_face   = r_o_face;
        n_o_side   = r_o_side;
        n_o_status = r_o_status;
        o_in_ready  = (r_state == S_IDLE) && i_map_ready;
        o_div_start = 1'b0;
        o_div_num   = DIV_NW'(r_column) << (F + 1);
        o_div_den   = DIV_DW'(SCREEN_COLUMNS);
        o_map_we    = 1'b0;
        o_map_waddr = AW'(AW'(i_cell_y) * AW'(MAP_SIDE) + AW'(i_cell_x));
        o_map_wdata = i_cell_wall;
        o_map_re    = 1'b0;
        o_map_raddr = AW'(AW'(ny) * AW'(MAP_SIDE) + AW'(nx));
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_column = i_column;
                    if ((t_mode'(i_mode) == MODE_WRITE) && (int'(i_cell_x) < MAP_SIDE)
                        && (int'(i_cell_y) < MAP_SIDE)) begin
                        o_map_we = 1'b1;
                    end
                end
            end
            S_CAM_GO: begin
                if (COLS_POW2) begin
                    n_cam = cam_q - (CAM_W'(1) << F);
                end else begin
                    o_div_start = 1'b1;
                end
            end
            S_CAM_WAIT: begin
                n_cam = $signed({1'b0, i_div_quot[CAM_W-2:0]}) - (CAM_W'(1) << F);
            end
            S_RAY: begin
                n_rx = RAY_W'(shx) + RAY_W'(i_dir_x);
                n_ry = RAY_W'(shy) + RAY_W'(i_dir_y);
            end
            S_DX_GO: begin
                o_div_num = DIV_NW'(1) << (2 * F);
                o_div_den = DIV_DW'(abs_x);
                o_div_start = (r_rx != '0);
                n_ddx = DIST_MAX;
            end
            S_DX_WAIT: begin
                n_ddx = quot_sat;
            end
            S_DY_GO: begin
                o_div_num = DIV_NW'(1) << (2 * F);
                o_div_den = DIV_DW'(abs_y);
                o_div_start = (r_ry != '0);
                n_ddy = DIST_MAX;
            end
            S_DY_WAIT: begin
                n_ddy = quot_sat;
            end
            S_FIRST: begin
                n_distx = (fsh_x > (FD_W-F)'(DIST_MAX)) ? DIST_MAX : DIST_W'(fsh_x);
                n_disty = (fsh_y > (FD_W-F)'(DIST_MAX)) ? DIST_MAX : DIST_W'(fsh_y);
                n_mx    = MAP_W'(int_x);
                n_my    = MAP_W'(int_y);
                n_hx    = CELL_W'(int_x);
                n_hy    = CELL_W'(int_y);
                n_face  = FACE_POS_X;
                n_side  = '0;
                n_status = ST_OUT;
            end
            S_STEP: begin
                if (go_x) begin
                    n_side  = r_distx;
                    n_distx = sum_x[DIST_W] ? DIST_MAX : sum_x[DIST_W-1:0];
                    n_face  = rx_pos ? FACE_POS_X : FACE_NEG_X;
                end else begin
                    n_side  = r_disty;
                    n_disty = sum_y[DIST_W] ? DIST_MAX : sum_y[DIST_W-1:0];
                    n_face  = ry_pos ? FACE_POS_Y : FACE_NEG_Y;
                end
                if (step_out) begin
                    n_status = ST_OUT;
                end else begin
                    o_map_re = 1'b1;
                    n_mx = nx;
                    n_my = ny;
                    n_hx = CELL_W'(nx);
                    n_hy = CELL_W'(ny);
                end
            end
            S_CHECK: begin
                if (i_map_rdata) begin
                    n_status = ST_HIT;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_col    = r_column;
                    n_o_hx     = r_hx;
                    n_o_hy     = r_hy;
                    n_o_face   = r_face;
                    n_o_side   = r_side;
                    n_o_status = r_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_column   <= n_column;
        r_cam      <= n_cam;
        r_rx       <= n_rx;
        r_ry       <= n_ry;
        r_ddx      <= n_ddx;
        r_ddy      <= n_ddy;
        r_distx    <= n_distx;
        r_disty    <= n_disty;
        r_mx       <= n_mx;
        r_my       <= n_my;
        r_hx       <= n_hx;
        r_hy       <= n_hy;
        r_face     <= n_face;
        r_side     <= n_side;
        r_status   <= n_status;
        r_o_col    <= n_o_col;
        r_o_hx     <= n_o_hx;
        r_o_hy     <= n_o_hy;
        r_o_face   <= n_o_face;
        r_o_side   <= n_o_side;
        r_o_status <= n_o_status;
    end

    assign o_out_valid     = r_ovalid;
    assign o_ray_column    = r_o_col;
    assign o_hit_x         = r_o_hx;
    assign o_hit_y         = r_o_hy;
    assign o_face          = r_o_face;
    assign o_side_distance = r_o_side;
    assign o_status        = r_o_status;
endmodule

>>> design/grid_ray_dda_caster_unit.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_caster_unit
// DDA ray caster over a one-bit wall map held in block memory.
// ----------------------------------------------------------------------------
// A write word (mode 0) stores one map cell and leaves the unit ready for the
// next word; a cast word (mode 1) returns one result word. The camera offset
// is a shift when SCREEN_COLUMNS is a power of two, else a division on the
// shared one-bit-per-cycle divider. 1/|ray x| and 1/|ray y| then run on that
// divider, each skipped and saturated for a zero component; then each map
// cell walked takes a memory read and a test, and a step that would leave the
// map ends the walk without a read. One cast is in flight at a time; the next
// word is taken while the last result waits in the output register. After
// reset the map is swept to open, one cell per cycle, over all cells;
// input words are held off during the sweep, configuration writes are taken
// at any time.
module grid_ray_dda_caster_unit #(
    parameter int SCREEN_COLUMNS = grdc_pkg::DEF_SCREEN_COLUMNS,
    parameter int MAP_SIDE       = grdc_pkg::DEF_MAP_SIDE,
    parameter int FRAC_BITS      = grdc_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic [grdc_pkg::COL_W-1:0]         i_column,
    input  logic [grdc_pkg::CELL_W-1:0]        i_cell_x,
    input  logic [grdc_pkg::CELL_W-1:0]        i_cell_y,
    input  logic                               i_cell_wall,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [grdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [grdc_pkg::POS_W-1:0]         i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [grdc_pkg::COL_W-1:0]         o_ray_column,
    output logic [grdc_pkg::CELL_W-1:0]        o_hit_x,
    output logic [grdc_pkg::CELL_W-1:0]        o_hit_y,
    output logic [1:0]                         o_face,
    output logic [grdc_pkg::DIST_W-1:0]        o_side_distance,
    output logic                               o_status
);
    import grdc_pkg::*;

    localparam int CAM_W  = FRAC_BITS + COL_W + 2;
    localparam int DIV_NW = (2 * FRAC_BITS + 1 > FRAC_BITS + COL_W + 1)
                            ? 2 * FRAC_BITS + 1 : FRAC_BITS + COL_W + 1;
    localparam int DIV_DW = VEC_W + CAM_W - FRAC_BITS + 1;
    localparam int AW     = $clog2(MAP_SIDE * MAP_SIDE);

    logic [POS_W-1:0]        r_pos_x, r_pos_y;
    logic signed [VEC_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den;
    logic              map_ready, map_we, map_wdata, map_re, map_rdata;
    logic [AW-1:0]     map_waddr, map_raddr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= RST_POS_X;
            r_pos_y   <= RST_POS_Y;
            r_dir_x   <= RST_DIR_X;
            r_dir_y   <= RST_DIR_Y;
            r_plane_x <= RST_PLANE_X;
            r_plane_y <= RST_PLANE_Y;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data[VEC_W-1:0];
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data[VEC_W-1:0];
                CFG_PLANE_X: r_plane_x <= i_cfg_data[VEC_W-1:0];
                CFG_PLANE_Y: r_plane_y <= i_cfg_data[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    grdc_div #(
        .NUM_W (DIV_NW),
        .DEN_W (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    grdc_map #(
        .MAP_SIDE (MAP_SIDE)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata),
        .o_ready (map_ready)
    );

    grdc_ctrl #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .MAP_SIDE       (MAP_SIDE),
        .FRAC_BITS      (FRAC_BITS),
        .DIV_NW         (DIV_NW),
        .DIV_DW         (DIV_DW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_column        (i_column),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_wall     (i_cell_wall),
        .i_pos_x         (r_pos_x),
        .i_pos_y         (r_pos_y),
        .i_dir_x         (r_dir_x),
        .i_dir_y         (r_dir_y),
        .i_plane_x       (r_plane_x),
        .i_plane_y       (r_plane_y),
        .o_div_start     (div_start),
        .o_div_num       (div_num),
        .o_div_den       (div_den),
        .i_div_done      (div_done),
        .i_div_quot      (div_quot),
        .i_map_ready     (map_ready),
        .o_map_we        (map_we),
        .o_map_waddr     (map_waddr),
        .o_map_wdata     (map_wdata),
        .o_map_re        (map_re),
        .o_map_raddr     (map_raddr),
        .i_map_rdata     (map_rdata),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ray_column    (o_ray_column),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_face          (o_face),
        .o_side_distance (o_side_distance),
        .o_status        (o_status)
    );
endmodule

>>> design/grdc_checker.sv
// ----------------------------------------------------------------------------
// grdc_checker
// Port-level checks for the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
module grdc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_mode,
    input logic [grdc_pkg::COL_W-1:0]         i_column,
    input logic [grdc_pkg::CELL_W-1:0]        i_cell_x,
    input logic [grdc_pkg::CELL_W-1:0]        i_cell_y,
    input logic                               i_cell_wall,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [grdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [grdc_pkg::POS_W-1:0]         i_cfg_data,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [grdc_pkg::COL_W-1:0]         o_ray_column,
    input logic [grdc_pkg::CELL_W-1:0]        o_hit_x,
    input logic [grdc_pkg::CELL_W-1:0]        o_hit_y,
    input logic [1:0]                         o_face,
    input logic [grdc_pkg::DIST_W-1:0]        o_side_distance,
    input logic                               o_status
);
    import grdc_pkg::*;

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_ray_column) && $stable(o_hit_x)
            && $stable(o_hit_y) && $stable(o_face) && $stable(o_side_distance)
            && $stable(o_status))
        else $error("result word changed while stalled");

    // map sweep holds off input after reset
    a_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input taken during map sweep");

    a_write_1cyc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_WRITE) |=> o_in_ready)
        else $error("cell write stalled input");

    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_CAST) |=> !o_in_ready)
        else $error("cast did not occupy the unit");
endmodule

bind grid_ray_dda_caster_unit grdc_checker u_grdc_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid ray DDA caster unit.
// ----------------------------------------------------------------------------
// Map writes and ray casts go in through a queue-fed driver. Each accepted
// cast is predicted by a DDA walk over a shadow wall map and the shadow view
// registers. The monitor checks every result word against the oldest
// prediction. Phases change the view setup, including its extremes and zero
// ray components, and vary the idle and stall rates on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import grdc_pkg::*;

    localparam int        MAP_N    = DEF_MAP_SIDE;
    localparam longint    ONE      = 64'd1 << DEF_FRAC_BITS;
    localparam longint    SAT      = 64'hFFFFFF;
    localparam int        DRAIN    = 800;

    typedef struct {
        t_mode            mode;
        logic [COL_W-1:0]  column;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic              wall;
    } t_word;

    typedef struct {
        logic [COL_W-1:0]  column;
        logic [CELL_W-1:0] hx;
        logic [CELL_W-1:0] hy;
        t_face             face;
        logic [DIST_W-1:0] side;
        t_status           status;
    } t_hit;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode = 1'b0;
    logic [COL_W-1:0]      i_column = '0;
    logic [CELL_W-1:0]     i_cell_x = '0;
    logic [CELL_W-1:0]     i_cell_y = '0;
    logic                  i_cell_wall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [POS_W-1:0]      i_cfg_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [COL_W-1:0]      o_ray_column;
    logic [CELL_W-1:0]     o_hit_x;
    logic [CELL_W-1:0]     o_hit_y;
    logic [1:0]            o_face;
    logic [DIST_W-1:0]     o_side_distance;
    logic                  o_status;

    grid_ray_dda_caster_unit dut (.*);

    t_word pending_words[$];
    t_hit  expected_hits[$];

    bit                    wall_map[MAP_N*MAP_N];
    logic [POS_W-1:0]      sh_pos_x, sh_pos_y;
    logic signed [VEC_W-1:0] sh_dir_x, sh_dir_y, sh_plane_x, sh_plane_y;

    logic in_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   errors = 0;
    int   n_cast = 0, n_write = 0, n_hit = 0, n_out = 0, n_cfg = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
    endtask

    function automatic longint ray_delta(input longint d);
        longint q;
        if (d == 0) return SAT;
        q = (64'd1 << (2*DEF_FRAC_BITS)) / (d < 0 ? -d : d);
        return q > SAT ? SAT : q;
    endfunction

    function automatic longint first_side(input longint pos, input longint d, input longint dl);
        longint frac, part, r;
        frac = pos & (ONE - 1);
        part = d > 0 ? ONE - frac : frac;
        r = (part * dl) >> DEF_FRAC_BITS;
        return r > SAT ? SAT : r;
    endfunction

    function automatic void predict_ray(input logic [COL_W-1:0] col);
        longint cam, rx, ry, ddx, ddy, distx, disty, side, mx, my, nx, ny, sx, sy;
        t_hit   h;
        cam  = longint'(col) * 2 * ONE / DEF_SCREEN_COLUMNS - ONE;
        rx   = longint'(sh_dir_x) + ((longint'(sh_plane_x) * cam) >>> DEF_FRAC_BITS);
        ry   = longint'(sh_dir_y) + ((longint'(sh_plane_y) * cam) >>> DEF_FRAC_BITS);
        ddx  = ray_delta(rx);
        ddy  = ray_delta(ry);
        distx = first_side(longint'(sh_pos_x), rx, ddx);
        disty = first_side(longint'(sh_pos_y), ry, ddy);
        sx = rx > 0 ? 1 : -1;
        sy = ry > 0 ? 1 : -1;
        mx = longint'(sh_pos_x) >> DEF_FRAC_BITS;
        my = longint'(sh_pos_y) >> DEF_FRAC_BITS;
        side = 0;
        h.face   = FACE_POS_X;
        h.status = ST_OUT;
        if (mx < MAP_N && my < MAP_N) begin
            for (int g = 0; g < 4*MAP_N + 4; g++) begin
                nx = mx;
                ny = my;
                if (distx < disty) begin
                    side  = distx;
                    distx = distx + ddx > SAT ? SAT : distx + ddx;
                    nx    = nx + sx;
                    h.face = sx > 0 ? FACE_POS_X : FACE_NEG_X;
                end else begin
                    side  = disty;
                    disty = disty + ddy > SAT ? SAT : disty + ddy;
                    ny    = ny + sy;
                    h.face = sy > 0 ? FACE_POS_Y : FACE_NEG_Y;
                end
                if (nx < 0 || ny < 0 || nx >= MAP_N || ny >= MAP_N) begin
                    h.status = ST_OUT;
                    break;
                end
                mx = nx;
                my = ny;
                if (wall_map[my*MAP_N + mx]) begin
                    h.status = ST_HIT;
                    break;
                end
            end
        end
        h.column = col;
        h.hx     = mx[CELL_W-1:0];
        h.hy     = my[CELL_W-1:0];
        h.side   = side[DIST_W-1:0];
        expected_hits.push_back(h);
    endfunction

    // monitor: handshakes, shadow state, result check
    always @(posedge i_clk) begin
        t_hit e;
        in_taken  <= i_in_valid && o_in_ready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg++;
                case (t_cfg_idx'(i_cfg_index))
                    CFG_POS_X:   sh_pos_x   = i_cfg_data;
                    CFG_POS_Y:   sh_pos_y   = i_cfg_data;
                    CFG_DIR_X:   sh_dir_x   = i_cfg_data[VEC_W-1:0];
                    CFG_DIR_Y:   sh_dir_y   = i_cfg_data[VEC_W-1:0];
                    CFG_PLANE_X: sh_plane_x = i_cfg_data[VEC_W-1:0];
                    CFG_PLANE_Y: sh_plane_y = i_cfg_data[VEC_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result word, column", o_ray_column, -1);
                end else begin
                    e = expected_hits.pop_front();
                    if (e.status == ST_HIT) n_hit++;
                    else n_out++;
                    if (o_ray_column !== e.column)
                        report_mismatch("ray_column", o_ray_column, e.column);
                    if (o_hit_x !== e.hx)
                        report_mismatch("hit_x", o_hit_x, e.hx);
                    if (o_hit_y !== e.hy)
                        report_mismatch("hit_y", o_hit_y, e.hy);
                    if (o_face !== e.face)
                        report_mismatch("face", o_face, e.face);
                    if (o_side_distance !== e.side)
                        report_mismatch("side_distance", o_side_distance, e.side);
                    if (o_status !== e.status)
                        report_mismatch("status", o_status, e.status);
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (t_mode'(i_mode) == MODE_WRITE) begin
                    n_write++;
                    wall_map[int'(i_cell_y)*MAP_N + int'(i_cell_x)] = i_cell_wall;
                end else begin
                    n_cast++;
                    predict_ray(i_column);
                end
            end
        end
    end

    // input driver and result-channel ready
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                i_mode      <= w.mode;
                i_column    <= w.column;
                i_cell_x    <= w.cx;
                i_cell_y    <= w.cy;
                i_cell_wall <= w.wall;
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [POS_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [VEC_W-1:0] dx, input logic [VEC_W-1:0] dy,
                            input logic [VEC_W-1:0] qx, input logic [VEC_W-1:0] qy);
        cfg_write(CFG_POS_X, px);
        cfg_write(CFG_POS_Y, py);
        cfg_write(CFG_DIR_X, {4'($urandom_range(15)), dx});
        cfg_write(CFG_DIR_Y, {4'($urandom_range(15)), dy});
        cfg_write(CFG_PLANE_X, {4'($urandom_range(15)), qx});
        cfg_write(CFG_PLANE_Y, {4'($urandom_range(15)), qy});
    endtask

    task automatic push_write(input int x, input int y, input bit wall);
        t_word w;
        w.mode = MODE_WRITE;
        w.column = COL_W'($urandom_range(1023));
        w.cx = CELL_W'(x);
        w.cy = CELL_W'(y);
        w.wall = wall;
        pending_words.push_back(w);
    endtask

    task automatic push_cast(input int col);
        t_word w;
        w.mode = MODE_CAST;
        w.column = COL_W'(col);
        w.cx = CELL_W'($urandom_range(63));
        w.cy = CELL_W'($urandom_range(63));
        w.wall = 1'($urandom_range(1));
        pending_words.push_back(w);
    endtask

    task automatic settle;
        wait (pending_words.size() == 0 && !i_in_valid && expected_hits.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    initial begin
        int px, py;
        sh_pos_x = RST_POS_X;   sh_pos_y = RST_POS_Y;
        sh_dir_x = RST_DIR_X;   sh_dir_y = RST_DIR_Y;
        sh_plane_x = RST_PLANE_X; sh_plane_y = RST_PLANE_Y;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset view first, then a box near the middle
        push_cast(0);
        push_cast(1023);
        settle();
        set_view(22'h20_8000, 22'h20_8000, 18'sd65536, 18'sd0, 18'sd0, 18'sd43254);
        push_write(40, 32, 1);
        push_write(32, 40, 1);
        push_write(32, 20, 1);
        push_write(0, 0, 1);
        push_write(63, 63, 1);
        push_cast(512);
        push_cast(511);
        push_cast(0);
        push_cast(1023);
        push_write(40, 32, 0);
        push_cast(512);
        push_write(33, 32, 1);
        push_cast(512);
        push_write(33, 32, 0);
        settle();
        // zero ray y component, then max corner position with extreme vectors
        set_view(22'h00_8000, 22'h3F_8000, 18'sd65536, 18'sd0, 18'sd0, 18'sd0);
        push_cast(512);
        push_cast(100);
        settle();
        set_view(22'h3F_FFFF, 22'h3F_FFFF, 18'sd131071, 18'sd131071,
                 -18'sd131072, -18'sd131072);
        push_cast(0);
        push_cast(1023);
        settle();
        set_view(22'h0, 22'h0, -18'sd131072, -18'sd131072, 18'sd131071, 18'sd131071);
        push_cast(0);
        push_cast(1023);
        push_cast(512);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            send_idle_pct  = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 13 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 13 : 0;
            case (ph)
                0: set_view(POS_W'($urandom_range(22'h3F_FFFF)),
                            POS_W'($urandom_range(22'h3F_FFFF)),
                            18'sd0, -18'sd65536, 18'sd0, 18'sd0);
                1: set_view(22'h3F_FFFF, 22'h0, -18'sd131072, 18'sd131071,
                            18'sd131071, -18'sd131072);
                default: set_view(POS_W'($urandom_range(22'h3F_FFFF)),
                                  POS_W'($urandom_range(22'h3F_FFFF)),
                                  VEC_W'($urandom), VEC_W'($urandom),
                                  VEC_W'($urandom), VEC_W'($urandom));
            endcase
            px = int'(sh_pos_x >> DEF_FRAC_BITS);
            py = int'(sh_pos_y >> DEF_FRAC_BITS);
            for (int k = 0; k < 72; k++) begin
                if ($urandom_range(99) < 45) begin
                    if ($urandom_range(1))
                        push_write($urandom_range(63), $urandom_range(63),
                                   $urandom_range(99) < 80);
                    else
                        push_write((px + $urandom_range(16) - 8) & 63,
                                   (py + $urandom_range(16) - 8) & 63,
                                   $urandom_range(99) < 70);
                end else begin
                    push_cast($urandom_range(1023));
                end
            end
            if (ph == 4) begin
                // clear 40 random cells so rays run longer
                for (int k = 0; k < 40; k++)
                    push_write($urandom_range(63), $urandom_range(63), 1'b0);
            end
        end
        settle();
        $display("Covered %0d casts (%0d wall hits, %0d left the map), %0d map writes,",
                 n_cast, n_hit, n_out, n_write);
        $display("%0d register writes over 12 view setups and four idle/stall mixes.",
                 n_cfg);
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
